>>> rtl/vwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwm_pkg: shared types and constants of the variant window matcher
// Item and result layouts, table entry layout, register map and sequencer
// states used by the matcher modules.
// ----------------------------------------------------------------------------
package vwm_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = ADDR_W + 1;

  localparam int CHROM_W = 7;
  localparam int POS_W   = 30;
  localparam int LEN_W   = 20;
  localparam int WIN_W   = 16;

  // Item function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Register word index, taken from paddr[2].
  localparam logic REG_WINDOW_BP         = 1'b0;
  localparam logic REG_REQUIRE_SAME_SIZE = 1'b1;

  localparam logic [WIN_W-1:0] WINDOW_BP_RESET = 16'd10;
  localparam logic             REQUIRE_SAME_SIZE_RESET = 1'b1;

  typedef enum logic [1:0] {
    EV_SNP = 2'd0,
    EV_INS = 2'd1,
    EV_DEL = 2'd2,
    EV_RPL = 2'd3
  } ev_type_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEARCH,
    ST_SCAN,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic               func;
    logic [CHROM_W-1:0] chromosome;
    logic [POS_W-1:0]   position;
    logic [LEN_W-1:0]   ref_length;
    logic [LEN_W-1:0]   alt_length;
    logic               first_base_equal;
  } req_item_t;

  typedef struct packed {
    logic found;
    logic load_rejected;
  } rsp_item_t;

  typedef struct packed {
    logic [CHROM_W-1:0] chromosome;
    logic [POS_W-1:0]   position;
    ev_type_t           etype;
    logic [LEN_W-1:0]   size;
  } entry_t;

  typedef struct packed {
    logic [WIN_W-1:0] window_bp;
    logic             require_same_size;
  } cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

>>> rtl/variant_window_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variant_window_matcher: sorted variant table with windowed similarity match
// Loads append typed variant entries to a table in memory (or are rejected when
// it is full); queries search the table for an entry of the same type (and size) near a position.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_stall   req_item   (vwm_pkg::req_item_t)
//   rsp       out        rsp_valid/rsp_stall   rsp_item   (vwm_pkg::rsp_item_t)
//   config    in         APB psel/penable      paddr/pwdata/prdata, pready tied high
//
// The item is classified as it is taken. A load then passes through the prep
// state, where the table memory is written, and the reply state, where the
// result is handed to the output register once that is free, and returns to
// idle, where the next transfer is taken. A query passes through the prep
// state, the halving steps of the lower-bound search (about
// log2(entries + 1) steps, 13 for a full 4096-entry table) and a scan of the
// entries inside the window before its reply. Both the search and the scan are set by
// the single read port of the table memory, one entry per cycle.
// Reset is synchronous and clears the entry count, the sequencer and the
// output register; the table memory itself is not cleared, since only
// entries below the count are ever read. A stalled result sits in the output
// register while the sequencer holds its own result and stalls new items.
//
module variant_window_matcher (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  vwm_pkg::req_item_t req_item,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output vwm_pkg::rsp_item_t rsp_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import vwm_pkg::*;

  cfg_t      cfg;
  logic      res_valid;
  logic      res_ready;
  rsp_item_t res_item;
  mem_req_t  mem_req;
  entry_t    rd_data;
  logic      cfg_write;

  // Configuration registers. The word index is paddr[2]; the byte offset
  // bits are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_bp         <= WINDOW_BP_RESET;
      cfg.require_same_size <= REQUIRE_SAME_SIZE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_WINDOW_BP:         cfg.window_bp         <= pwdata[WIN_W-1:0];
        REG_REQUIRE_SAME_SIZE: cfg.require_same_size <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WINDOW_BP:         prdata = {{(32 - WIN_W){1'b0}}, cfg.window_bp};
      REG_REQUIRE_SAME_SIZE: prdata = {31'd0, cfg.require_same_size};
      default:               prdata = '0;
    endcase
  end

  // The sequencer runs loads, searches and scans against the table memory.
  vwm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  vwm_table_ram #(
    .DEPTH  (TABLE_DEPTH),
    .WIDTH  ($bits(entry_t)),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  // Output register: it takes a new result whenever it is empty or its
  // current result is leaving in this cycle.
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp_item <= res_item;
    end
  end

endmodule

>>> rtl/vwm_table_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwm_table_ram: simple dual-port table memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module vwm_table_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 59,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/vwm_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwm_engine: load, lower-bound search and window scan sequencer
// Takes one item at a time, appends loads to the table and runs queries as
// a binary search followed by a forward scan, one table read per cycle.
// ----------------------------------------------------------------------------
module vwm_engine (
  input  logic               clk,
  input  logic               rst,
  input  vwm_pkg::cfg_t      cfg,
  input  logic               req_valid,
  output logic               req_stall,
  input  vwm_pkg::req_item_t req_item,
  output logic               res_valid,
  input  logic               res_ready,
  output vwm_pkg::rsp_item_t res_item,
  output vwm_pkg::mem_req_t  mem_req,
  input  vwm_pkg::entry_t    rd_data
);

  import vwm_pkg::*;

  function automatic ev_type_t classify(input logic [LEN_W-1:0] rl,
                                        input logic [LEN_W-1:0] al,
                                        input logic fe);
    ev_type_t t;
    t = EV_RPL;
    if (rl == LEN_W'(1)) begin
      if (al == LEN_W'(1)) begin
        t = EV_SNP;
      end else if (al > LEN_W'(1) && fe) begin
        t = EV_INS;
      end
    end else if (rl > LEN_W'(1) && al == LEN_W'(1) && fe) begin
      t = EV_DEL;
    end
    return t;
  endfunction

  state_t state, state_next;

  logic [COUNT_W-1:0] entry_count;

  logic               q_func;
  logic [CHROM_W-1:0] q_chrom;
  logic [POS_W-1:0]   q_pos;
  logic [POS_W-1:0]   q_low;
  ev_type_t           q_type;
  logic [LEN_W-1:0]   q_size;
  logic [COUNT_W-1:0] first;
  logic [COUNT_W-1:0] span;
  logic [ADDR_W-1:0]  probe;
  logic               found;
  logic               rejected;

  logic               table_full;
  logic [POS_W:0]     low_diff;
  logic [POS_W-1:0]   low_clamp;
  logic [COUNT_W-1:0] count_half;
  logic               e_less;
  logic [COUNT_W-1:0] half;
  logic [COUNT_W-1:0] probe_inc;
  logic [COUNT_W-1:0] first_next;
  logic [COUNT_W-1:0] span_next;
  logic [COUNT_W-1:0] mid_next;
  logic [POS_W-1:0]   pos_gap;
  logic               in_window;
  logic               same_kind;
  logic               scan_more;

  assign table_full = (entry_count == COUNT_W'(TABLE_DEPTH));
  assign count_half = entry_count >> 1;

  // Lower search bound, clamped at position one.
  assign low_diff  = {1'b0, q_pos} - (POS_W + 1)'(cfg.window_bp);
  assign low_clamp = (q_pos <= POS_W'(cfg.window_bp)) ? POS_W'(1) : low_diff[POS_W-1:0];

  // One halving step of the lower-bound search on the entry just read.
  assign e_less     = {rd_data.chromosome, rd_data.position} < {q_chrom, q_low};
  assign half       = span >> 1;
  assign probe_inc  = {1'b0, probe} + COUNT_W'(1);
  assign first_next = e_less ? probe_inc : first;
  assign span_next  = e_less ? (span - half - COUNT_W'(1)) : half;
  assign mid_next   = first_next + (span_next >> 1);

  // Window test and match test on the scanned entry.
  assign pos_gap   = (rd_data.position >= q_pos) ? (rd_data.position - q_pos)
                                                 : (q_pos - rd_data.position);
  assign in_window = (rd_data.chromosome == q_chrom) && (pos_gap < POS_W'(cfg.window_bp));
  assign same_kind = (rd_data.etype == q_type) &&
                     (!cfg.require_same_size || (rd_data.size == q_size));
  assign scan_more = in_window && !same_kind && (probe_inc < entry_count);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (q_func == FUNC_LOAD || entry_count == '0) begin
          state_next = ST_REPLY;
        end else begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (span_next != '0) begin
          state_next = ST_SEARCH;
        end else if (first_next >= entry_count) begin
          state_next = ST_REPLY;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_more) begin
          state_next = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall              = (state != ST_IDLE);
    res_valid              = (state == ST_REPLY);
    res_item.found         = found;
    res_item.load_rejected = rejected;
    mem_req.wr_en          = 1'b0;
    mem_req.wr_addr        = entry_count[ADDR_W-1:0];
    mem_req.wr_data        = '{chromosome: q_chrom, position: q_pos,
                               etype: q_type, size: q_size};
    mem_req.rd_en          = 1'b0;
    mem_req.rd_addr        = count_half[ADDR_W-1:0];
    case (state)
      ST_PREP: begin
        if (q_func == FUNC_LOAD) begin
          mem_req.wr_en = !table_full;
        end else begin
          mem_req.rd_en = (entry_count != '0);
        end
      end
      ST_SEARCH: begin
        if (span_next != '0) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = mid_next[ADDR_W-1:0];
        end else begin
          mem_req.rd_en   = (first_next < entry_count);
          mem_req.rd_addr = first_next[ADDR_W-1:0];
        end
      end
      ST_SCAN: begin
        mem_req.rd_en   = scan_more;
        mem_req.rd_addr = probe_inc[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_PREP && q_func == FUNC_LOAD && !table_full) begin
        entry_count <= entry_count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          q_func  <= req_item.func;
          q_chrom <= req_item.chromosome;
          q_pos   <= req_item.position;
          q_type  <= classify(req_item.ref_length, req_item.alt_length,
                              req_item.first_base_equal);
          q_size  <= (req_item.ref_length >= req_item.alt_length)
                     ? (req_item.ref_length - req_item.alt_length)
                     : (req_item.alt_length - req_item.ref_length);
        end
      end
      ST_PREP: begin
        q_low    <= low_clamp;
        found    <= 1'b0;
        rejected <= (q_func == FUNC_LOAD) && table_full;
        first    <= '0;
        span     <= entry_count;
        probe    <= count_half[ADDR_W-1:0];
      end
      ST_SEARCH: begin
        first <= first_next;
        span  <= span_next;
        probe <= (span_next != '0) ? mid_next[ADDR_W-1:0] : first_next[ADDR_W-1:0];
      end
      ST_SCAN: begin
        if (in_window && same_kind) begin
          found <= 1'b1;
        end
        probe <= probe_inc[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/vwm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwm_checker: port-level checks for the variant window matcher
// Watches the item, result and configuration ports of the top level.
// ----------------------------------------------------------------------------
module vwm_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input vwm_pkg::rsp_item_t rsp_item,
  input logic               pready
);

  // A stalled result stays in place.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("stalled result changed or vanished");

  // One item at a time: the block stalls right after taking an item.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second item taken while one is in flight");

  // A result is either a query answer or a load status, never both.
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_item.found && rsp_item.load_rejected))
    else $error("result claims both found and load_rejected");

  // Reset leaves no result pending and the item side open.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("reset did not clear the result and item handshakes");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready dropped");

endmodule

bind variant_window_matcher vwm_checker u_vwm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_item  (rsp_item),
  .pready    (pready)
);
